@@ sv/kbsm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbsm_pkg: shared types and constants of the keystroke sequence matcher
// Command and result records, letter coding constants and command kinds.
// ----------------------------------------------------------------------------
package kbsm_pkg;

  localparam int FIELD_W     = 60;   // packed letter code and mask width
  localparam int ARG_W       = 64;   // argument port width
  localparam int IDX_W       = 6;    // slot index width on the ports
  localparam int IDX_SPAN    = 64;   // slots reachable by a 6-bit index
  localparam int LETTER_BITS = 5;
  localparam int CNT_W       = 4;

  localparam logic [7:0] KEY_LC_A = 8'h61;   // 'a'
  localparam logic [7:0] KEY_LC_END = 8'h80; // 'a' + 31
  localparam logic [7:0] KEY_UC_A = 8'h41;   // 'A'
  localparam logic [7:0] KEY_UC_Z = 8'h5A;   // 'Z'
  localparam logic [7:0] CASE_OFS = 8'h20;   // 'a' - 'A'

  // command kinds
  localparam logic CMD_KEY   = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // pattern table entry (valid bit kept apart in flip-flops)
  typedef struct packed {
    logic [FIELD_W-1:0] code;
    logic [FIELD_W-1:0] mask;
    logic [CNT_W-1:0]   arg_count;
    logic [7:0]         fixed_arg;
    logic [7:0]         cls;
  } entry_t;

  // classified item passed from front end to back end
  typedef struct packed {
    logic                         kind;
    logic [7:0]                   lkey;
    logic                         is_letter;
    logic [LETTER_BITS-1:0]       letter;
    logic [IDX_W-1:0]             slot;
    logic                         in_range;
    logic                         valid;
    entry_t                       entry;
  } cmd_t;

  typedef struct packed {
    logic              accepted;
    logic              fired;
    logic [IDX_W-1:0]  pattern_index;
    logic [ARG_W-1:0]  argument;
    logic [CNT_W-1:0]  argument_length;
  } res_t;

  localparam int CMD_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH = 2;

endpackage

@@ sv/keystroke_sequence_matcher_core.sv @@
`timescale 1ns / 1ps
// Path: table writes, capture keys and non-letter keys go through the command
//   queue and back end to the result queue; a letter key first scans the table.
// Throughput: one item per cycle for those kinds while results drain; a letter
//   key holds the back end for its scan, one pattern memory read a cycle.
// Reset: synchronous; clears history, capture state, table valid bits, queues.
// ----------------------------------------------------------------------------
// keystroke_sequence_matcher_core: multi-pattern keystroke detector
// Front end classifies items into a command queue; back end matches the key
// history against the pattern table and queues one result per item.
// ----------------------------------------------------------------------------
module keystroke_sequence_matcher_core import kbsm_pkg::*; #(
  parameter int NUM_PATTERNS = 64,
  parameter int MAX_ARG_KEYS = 8,
  parameter int MAX_LETTERS  = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_func,
  input  logic [7:0]         in_key,
  input  logic [IDX_W-1:0]   in_entry_index,
  input  logic [FIELD_W-1:0] in_entry_code,
  input  logic [FIELD_W-1:0] in_entry_mask,
  input  logic               in_entry_valid,
  input  logic [CNT_W-1:0]   in_entry_arg_count,
  input  logic [7:0]         in_entry_fixed_arg,
  input  logic [7:0]         in_entry_class,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_accepted,
  output logic               out_fired,
  output logic [IDX_W-1:0]   out_pattern_index,
  output logic [ARG_W-1:0]   out_argument,
  output logic [CNT_W-1:0]   out_argument_length
);

  logic [7:0] inhibit_r;
  logic       cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t       cmd_in, cmd_head;
  logic       res_push, res_full;
  res_t       res_in, res_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inhibit_r <= '0;
    end else if (cfg_wr_en) begin
      inhibit_r <= cfg_wr_data;
    end
  end

  kbsm_front #(
    .NUM_PATTERNS(NUM_PATTERNS),
    .MAX_ARG_KEYS(MAX_ARG_KEYS)
  ) u_front (
    .in_push           (in_push),
    .in_full           (in_full),
    .in_func           (in_func),
    .in_key            (in_key),
    .in_entry_index    (in_entry_index),
    .in_entry_code     (in_entry_code),
    .in_entry_mask     (in_entry_mask),
    .in_entry_valid    (in_entry_valid),
    .in_entry_arg_count(in_entry_arg_count),
    .in_entry_fixed_arg(in_entry_fixed_arg),
    .in_entry_class    (in_entry_class),
    .cmd_push          (cmd_push),
    .cmd_data          (cmd_in),
    .cmd_full          (cmd_full)
  );

  kbsm_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_data(cmd_in),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .head_data(cmd_head),
    .empty    (cmd_empty)
  );

  kbsm_back #(
    .NUM_PATTERNS(NUM_PATTERNS),
    .MAX_ARG_KEYS(MAX_ARG_KEYS),
    .MAX_LETTERS (MAX_LETTERS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .inhibit  (inhibit_r),
    .cmd_empty(cmd_empty),
    .cmd_data (cmd_head),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_in)
  );

  kbsm_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RES_Q_DEPTH)
  ) u_res_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res_in),
    .full     (res_full),
    .pop      (out_pop),
    .head_data(res_head),
    .empty    (out_empty)
  );

  assign out_accepted        = res_head.accepted;
  assign out_fired           = res_head.fired;
  assign out_pattern_index   = res_head.pattern_index;
  assign out_argument        = res_head.argument;
  assign out_argument_length = res_head.argument_length;

endmodule

@@ sv/kbsm_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbsm_fifo: small synchronous queue
// Register-based FIFO used between front end, back end and result port.
// ----------------------------------------------------------------------------
module kbsm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == (PW+1)'(DEPTH));
  assign empty     = (cnt_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_data = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ sv/kbsm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbsm_front: input front end
// Accepts items, lower-cases and letter-codes keys, checks and saturates
// table write fields, and queues the classified command.
// ----------------------------------------------------------------------------
module kbsm_front import kbsm_pkg::*; #(
  parameter int NUM_PATTERNS = 64,
  parameter int MAX_ARG_KEYS = 8
) (
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_func,
  input  logic [7:0]         in_key,
  input  logic [IDX_W-1:0]   in_entry_index,
  input  logic [FIELD_W-1:0] in_entry_code,
  input  logic [FIELD_W-1:0] in_entry_mask,
  input  logic               in_entry_valid,
  input  logic [CNT_W-1:0]   in_entry_arg_count,
  input  logic [7:0]         in_entry_fixed_arg,
  input  logic [7:0]         in_entry_class,
  output logic               cmd_push,
  output cmd_t               cmd_data,
  input  logic               cmd_full
);

  localparam int TBL_DEPTH = (NUM_PATTERNS < IDX_SPAN) ? NUM_PATTERNS : IDX_SPAN;

  logic [7:0]       lkey;
  logic [7:0]       ofs;
  logic [CNT_W-1:0] cnt_sat;

  assign in_full  = cmd_full;
  assign cmd_push = in_push && !cmd_full;

  always_comb begin
    lkey = in_key;
    if (in_key >= KEY_UC_A && in_key <= KEY_UC_Z) begin
      lkey = in_key + CASE_OFS;
    end
    ofs     = lkey - KEY_LC_A;
    cnt_sat = (in_entry_arg_count > CNT_W'(MAX_ARG_KEYS)) ? CNT_W'(MAX_ARG_KEYS)
                                                          : in_entry_arg_count;

    cmd_data                 = '0;
    cmd_data.kind            = in_func ? CMD_WRITE : CMD_KEY;
    cmd_data.lkey            = lkey;
    cmd_data.is_letter       = (lkey >= KEY_LC_A) && (lkey <= KEY_LC_END);
    cmd_data.letter          = ofs[LETTER_BITS-1:0];
    cmd_data.slot            = in_entry_index;
    cmd_data.in_range        = ({1'b0, in_entry_index} < (IDX_W+1)'(TBL_DEPTH));
    cmd_data.valid           = in_entry_valid;
    cmd_data.entry.code      = in_entry_code;
    cmd_data.entry.mask      = in_entry_mask;
    cmd_data.entry.arg_count = cnt_sat;
    cmd_data.entry.fixed_arg = in_entry_fixed_arg;
    cmd_data.entry.cls       = in_entry_class;
  end

endmodule

@@ sv/kbsm_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbsm_back: execution back end
// Holds the pattern table, key history and capture state. Table writes,
// capture keys and non-letter keys finish in the idle state; letter keys scan
// the table one entry per cycle through the registered memory read port.
// ----------------------------------------------------------------------------
module kbsm_back import kbsm_pkg::*; #(
  parameter int NUM_PATTERNS = 64,
  parameter int MAX_ARG_KEYS = 8,
  parameter int MAX_LETTERS  = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] inhibit,
  input  logic       cmd_empty,
  input  cmd_t       cmd_data,
  output logic       cmd_pop,
  input  logic       res_full,
  output logic       res_push,
  output res_t       res_data
);

  localparam int TBL_DEPTH = (NUM_PATTERNS < IDX_SPAN) ? NUM_PATTERNS : IDX_SPAN;
  localparam int AW        = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int HIST_W    = MAX_LETTERS * LETTER_BITS;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // pattern memory
  entry_t         mem [TBL_DEPTH];
  entry_t         rd_data_r;
  logic           mem_we;

  logic           state_r, state_nxt;
  logic [HIST_W-1:0]    hist_r, hist_nxt;
  logic [TBL_DEPTH-1:0] valid_r, valid_nxt;
  logic           rd_vld_r;
  logic [CNT_W-1:0]     pend_r, pend_nxt;
  logic [IDX_W-1:0]     cap_slot_r, cap_slot_nxt;
  logic [ARG_W-1:0]     cap_buf_r, cap_buf_nxt;
  logic [CNT_W-1:0]     cap_len_r, cap_len_nxt;
  logic [AW-1:0]        rd_addr_r, rd_addr_nxt;
  logic           issue_r, issue_nxt;
  logic           eval_v_r;
  logic           eval_last_r;
  logic [AW-1:0]        eval_idx_r;
  logic           acc_r, acc_nxt;
  logic           fired_r, fired_nxt;
  logic [IDX_W-1:0]     fidx_r, fidx_nxt;
  logic [7:0]           farg_r, farg_nxt;

  logic [FIELD_W-1:0]   hist_ext;
  logic [HIST_W+LETTER_BITS-1:0] hist_shl;
  logic           hit;

  always_comb begin
    hist_ext = '0;
    hist_ext[HIST_W-1:0] = hist_r;
  end

  assign hist_shl = {hist_r, cmd_data.letter};
  assign hit = rd_vld_r && ((hist_ext & rd_data_r.mask) == rd_data_r.code) &&
               ((rd_data_r.cls & inhibit) == 8'h00);

  always_comb begin
    state_nxt    = state_r;
    hist_nxt     = hist_r;
    valid_nxt    = valid_r;
    pend_nxt     = pend_r;
    cap_slot_nxt = cap_slot_r;
    cap_buf_nxt  = cap_buf_r;
    cap_len_nxt  = cap_len_r;
    rd_addr_nxt  = rd_addr_r;
    issue_nxt    = issue_r;
    acc_nxt      = acc_r;
    fired_nxt    = fired_r;
    fidx_nxt     = fidx_r;
    farg_nxt     = farg_r;
    mem_we       = 1'b0;
    cmd_pop      = 1'b0;
    res_push     = 1'b0;
    res_data     = '0;

    case (state_r)
      ST_IDLE: begin
        // start only with room for the one result this command makes
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          if (cmd_data.kind == CMD_WRITE) begin
            if (cmd_data.in_range) begin
              mem_we = 1'b1;
              valid_nxt[cmd_data.slot[AW-1:0]] = cmd_data.valid;
            end
            res_push = 1'b1;
          end else if (pend_r != '0) begin
            // capture the lower-cased key; the last one fires the capturing pattern
            for (int b = 0; b < MAX_ARG_KEYS; b++) begin
              if (cap_len_r == CNT_W'(b)) begin
                cap_buf_nxt[8*b +: 8] = cap_buf_r[8*b +: 8] | cmd_data.lkey;
              end
            end
            if (cap_len_r < CNT_W'(MAX_ARG_KEYS)) begin
              cap_len_nxt = cap_len_r + 1'b1;
            end
            pend_nxt          = pend_r - 1'b1;
            res_push          = 1'b1;
            res_data.accepted = 1'b1;
            if (pend_r == CNT_W'(1)) begin
              res_data.fired           = 1'b1;
              res_data.pattern_index   = cap_slot_r;
              res_data.argument        = cap_buf_nxt;
              res_data.argument_length = cap_len_nxt;
            end
          end else if (!cmd_data.is_letter) begin
            hist_nxt = '0;
            res_push = 1'b1;
          end else begin
            hist_nxt    = hist_shl[HIST_W-1:0];
            rd_addr_nxt = '0;
            issue_nxt   = 1'b1;
            acc_nxt     = 1'b0;
            fired_nxt   = 1'b0;
            fidx_nxt    = '0;
            farg_nxt    = '0;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issue_r) begin
          if (rd_addr_r == AW'(TBL_DEPTH-1)) begin
            issue_nxt = 1'b0;
          end else begin
            rd_addr_nxt = rd_addr_r + 1'b1;
          end
        end
        if (eval_v_r) begin
          if (hit && rd_data_r.arg_count != '0) begin
            // later capturing match overrides earlier one
            cap_slot_nxt = IDX_W'(eval_idx_r);
            pend_nxt     = rd_data_r.arg_count;
            cap_buf_nxt  = '0;
            cap_len_nxt  = '0;
            acc_nxt      = 1'b1;
          end else if (hit && !fired_r) begin
            fired_nxt = 1'b1;
            acc_nxt   = 1'b1;
            fidx_nxt  = IDX_W'(eval_idx_r);
            farg_nxt  = rd_data_r.fixed_arg;
          end
          if (eval_last_r) begin
            res_push               = 1'b1;
            res_data.accepted      = acc_nxt;
            res_data.fired         = fired_nxt;
            res_data.pattern_index = fidx_nxt;
            res_data.argument      = {{(ARG_W-8){1'b0}}, farg_nxt};
            state_nxt              = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hist_r      <= '0;
      valid_r     <= '0;
      pend_r      <= '0;
      cap_slot_r  <= '0;
      cap_buf_r   <= '0;
      cap_len_r   <= '0;
      issue_r     <= 1'b0;
      eval_v_r    <= 1'b0;
      eval_last_r <= 1'b0;
      acc_r       <= 1'b0;
      fired_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hist_r      <= hist_nxt;
      valid_r     <= valid_nxt;
      pend_r      <= pend_nxt;
      cap_slot_r  <= cap_slot_nxt;
      cap_buf_r   <= cap_buf_nxt;
      cap_len_r   <= cap_len_nxt;
      issue_r     <= issue_nxt;
      eval_v_r    <= issue_r;
      eval_last_r <= (rd_addr_r == AW'(TBL_DEPTH-1));
      acc_r       <= acc_nxt;
      fired_r     <= fired_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r  <= rd_addr_nxt;
    eval_idx_r <= rd_addr_r;
    fidx_r     <= fidx_nxt;
    farg_r     <= farg_nxt;
    rd_vld_r   <= valid_r[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd_data.slot[AW-1:0]] <= cmd_data.entry;
    end
    rd_data_r <= mem[rd_addr_r];
  end

endmodule

@@ sv/kbsm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbsm_checker: result port checks
// Watches the result channel of the matcher core and flags bad results.
// ----------------------------------------------------------------------------
module kbsm_checker import kbsm_pkg::*; #(
  parameter int MAX_ARG_KEYS = 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_empty,
  input logic              out_pop,
  input logic              out_accepted,
  input logic              out_fired,
  input logic [IDX_W-1:0]  out_pattern_index,
  input logic [ARG_W-1:0]  out_argument,
  input logic [CNT_W-1:0]  out_argument_length
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty)
    else $error("waiting result withdrawn");

  a_idle_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_fired |->
      out_pattern_index == '0 && out_argument == '0 && out_argument_length == '0)
    else $error("non-fire result carries event data");

  a_fire_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_fired |-> out_accepted)
    else $error("fire without accepted key");

  a_arg_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_argument_length <= CNT_W'(MAX_ARG_KEYS) &&
      (out_argument_length != '0 || out_argument[ARG_W-1:8] == '0))
    else $error("argument exceeds its length");

endmodule

bind keystroke_sequence_matcher_core kbsm_checker #(
  .MAX_ARG_KEYS(MAX_ARG_KEYS)
) u_kbsm_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_empty          (out_empty),
  .out_pop            (out_pop),
  .out_accepted       (out_accepted),
  .out_fired          (out_fired),
  .out_pattern_index  (out_pattern_index),
  .out_argument       (out_argument),
  .out_argument_length(out_argument_length)
);

@@ verif/keystroke_sequence_matcher_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keystroke_sequence_matcher_checker: scoreboard of the keystroke matcher
// Watches the command, result and register ports, predicts the result of
// every accepted command from its own copy of the pattern table, key history
// and capture state, and compares each popped result field by field.
// ----------------------------------------------------------------------------
module keystroke_sequence_matcher_checker import kbsm_pkg::*; #(
  parameter int NUM_PATTERNS = 64,
  parameter int MAX_ARG_KEYS = 8,
  parameter int MAX_LETTERS  = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_push,
  input  logic               in_full,
  input  logic               in_func,
  input  logic [7:0]         in_key,
  input  logic [IDX_W-1:0]   in_entry_index,
  input  logic [FIELD_W-1:0] in_entry_code,
  input  logic [FIELD_W-1:0] in_entry_mask,
  input  logic               in_entry_valid,
  input  logic [CNT_W-1:0]   in_entry_arg_count,
  input  logic [7:0]         in_entry_fixed_arg,
  input  logic [7:0]         in_entry_class,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic               out_accepted,
  input  logic               out_fired,
  input  logic [IDX_W-1:0]   out_pattern_index,
  input  logic [ARG_W-1:0]   out_argument,
  input  logic [CNT_W-1:0]   out_argument_length,
  output int                 fail_count,
  output int                 outstanding,
  output int                 fire_count,
  output int                 capture_count
);

  localparam logic [FIELD_W-1:0] HIST_MASK =
    FIELD_W'((64'd1 << (MAX_LETTERS * LETTER_BITS)) - 64'd1);

  // matcher state as seen from outside
  logic [7:0]         inhibit;
  logic [FIELD_W-1:0] key_hist;
  logic [FIELD_W-1:0] pat_code  [NUM_PATTERNS];
  logic [FIELD_W-1:0] pat_mask  [NUM_PATTERNS];
  logic               pat_valid [NUM_PATTERNS];
  logic [CNT_W-1:0]   pat_argc  [NUM_PATTERNS];
  logic [7:0]         pat_fixed [NUM_PATTERNS];
  logic [7:0]         pat_cls   [NUM_PATTERNS];
  logic [CNT_W-1:0]   keys_left;
  logic [IDX_W-1:0]   cap_slot;
  logic [ARG_W-1:0]   cap_buf;
  logic [CNT_W-1:0]   cap_len;

  res_t pending_results [$];
  int   errors;
  int   fires;
  int   captures;

  function automatic res_t predict_match_result(
    input logic               func,
    input logic [7:0]         key,
    input logic [IDX_W-1:0]   idx,
    input logic [FIELD_W-1:0] code,
    input logic [FIELD_W-1:0] mask,
    input logic               valid,
    input logic [CNT_W-1:0]   argc,
    input logic [7:0]         fixed,
    input logic [7:0]         cls
  );
    res_t       r;
    logic [7:0] lk;
    r = '0;
    if (func == CMD_WRITE) begin
      if (idx < NUM_PATTERNS) begin
        pat_code[idx]  = code;
        pat_mask[idx]  = mask;
        pat_valid[idx] = valid;
        pat_argc[idx]  = (argc > MAX_ARG_KEYS) ? CNT_W'(MAX_ARG_KEYS) : argc;
        pat_fixed[idx] = fixed;
        pat_cls[idx]   = cls;
      end
      return r;
    end
    lk = (key >= KEY_UC_A && key <= KEY_UC_Z) ? key + CASE_OFS : key;
    // capture takes the lower-cased key and bypasses the history
    if (keys_left != 0) begin
      if (cap_len < MAX_ARG_KEYS) begin
        cap_buf |= ARG_W'(lk) << (8 * cap_len);
        cap_len++;
      end
      keys_left--;
      r.accepted = 1'b1;
      if (keys_left == 0) begin
        r.fired           = 1'b1;
        r.pattern_index   = cap_slot;
        r.argument        = cap_buf;
        r.argument_length = cap_len;
      end
      return r;
    end
    if (lk < KEY_LC_A || lk > KEY_LC_END) begin
      key_hist = '0;
      return r;
    end
    key_hist = ((key_hist << LETTER_BITS) | FIELD_W'(lk - KEY_LC_A)) & HIST_MASK;
    // last capturing match wins, first immediate match fires
    for (int i = 0; i < NUM_PATTERNS; i++) begin
      if (pat_valid[i] && (key_hist & pat_mask[i]) == pat_code[i] &&
          (pat_cls[i] & inhibit) == 8'h00) begin
        if (pat_argc[i] != 0) begin
          cap_slot   = IDX_W'(i);
          keys_left  = pat_argc[i];
          cap_buf    = '0;
          cap_len    = '0;
          r.accepted = 1'b1;
        end else if (!r.fired) begin
          r.fired         = 1'b1;
          r.accepted      = 1'b1;
          r.pattern_index = IDX_W'(i);
          r.argument      = ARG_W'(pat_fixed[i]);
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [ARG_W-1:0] want,
                             input logic [ARG_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst_n) begin
      inhibit   = 8'h00;
      key_hist  = '0;
      keys_left = '0;
      cap_slot  = '0;
      cap_buf   = '0;
      cap_len   = '0;
      for (int i = 0; i < NUM_PATTERNS; i++) begin
        pat_valid[i] = 1'b0;
      end
      pending_results.delete();
    end else begin
      // compare first so a stray result is never paired with a new command
      if (out_pop && !out_empty) begin
        if (pending_results.size() == 0) begin
          $error("result with no expectation: fired=%0b index=%0d argument=0x%0h",
                 out_fired, out_pattern_index, out_argument);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("accepted", want.accepted, out_accepted);
          check_field("fired", want.fired, out_fired);
          check_field("pattern_index", want.pattern_index, out_pattern_index);
          check_field("argument", want.argument, out_argument);
          check_field("argument_length", want.argument_length, out_argument_length);
          if (want.fired) begin
            fires++;
            if (want.argument_length != 0) begin
              captures++;
            end
          end
        end
      end
      if (cfg_wr_en) begin
        inhibit = cfg_wr_data;
      end
      if (in_push && !in_full) begin
        pending_results.push_back(predict_match_result(in_func, in_key, in_entry_index,
          in_entry_code, in_entry_mask, in_entry_valid, in_entry_arg_count,
          in_entry_fixed_arg, in_entry_class));
      end
    end
    fail_count    <= errors;
    outstanding   <= pending_results.size();
    fire_count    <= fires;
    capture_count <= captures;
  end

endmodule

@@ verif/keystroke_sequence_matcher_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keystroke_sequence_matcher_core_tb: top of the keystroke matcher bench
// Loads pattern tables, types matching, broken and random key sequences
// under several inhibit settings with bursty input and a stalling result
// side, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module keystroke_sequence_matcher_core_tb import kbsm_pkg::*;;

  localparam int NUM_PATTERNS = 64;
  localparam int MAX_ARG_KEYS = 8;
  localparam int MAX_LETTERS  = 12;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 91;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 2 * (NUM_PATTERNS + 3);

  typedef struct {
    logic               func;
    logic [7:0]         key;
    logic [IDX_W-1:0]   idx;
    logic [FIELD_W-1:0] code;
    logic [FIELD_W-1:0] mask;
    logic               valid;
    logic [CNT_W-1:0]   argc;
    logic [7:0]         fixed;
    logic [7:0]         cls;
  } kbsm_item_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [7:0]         cfg_wr_data;
  logic               in_push;
  logic               in_full;
  logic               in_func;
  logic [7:0]         in_key;
  logic [IDX_W-1:0]   in_entry_index;
  logic [FIELD_W-1:0] in_entry_code;
  logic [FIELD_W-1:0] in_entry_mask;
  logic               in_entry_valid;
  logic [CNT_W-1:0]   in_entry_arg_count;
  logic [7:0]         in_entry_fixed_arg;
  logic [7:0]         in_entry_class;
  logic               out_empty;
  logic               out_pop;
  logic               out_accepted;
  logic               out_fired;
  logic [IDX_W-1:0]   out_pattern_index;
  logic [ARG_W-1:0]   out_argument;
  logic [CNT_W-1:0]   out_argument_length;
  int                 fail_count;
  int                 outstanding;
  int                 fire_count;
  int                 capture_count;

  // sender and receiver pacing
  int   burst_left;
  bit   no_gap;
  logic hold_req;
  logic hold_done;
  int   hold_left;
  int   pop_pct;
  int   pat_left;
  int   idle_cycles;
  int   item_count;
  int   setting_count;
  logic [7:0] inhibit_now;

  // patterns that can be typed back
  logic [FIELD_W-1:0] slot_code [IDX_SPAN];
  logic [FIELD_W-1:0] slot_mask [IDX_SPAN];
  int                 slot_len  [IDX_SPAN];
  bit                 slot_typable [IDX_SPAN];

  keystroke_sequence_matcher_core #(
    .NUM_PATTERNS(NUM_PATTERNS),
    .MAX_ARG_KEYS(MAX_ARG_KEYS),
    .MAX_LETTERS (MAX_LETTERS)
  ) DUT (.*);

  keystroke_sequence_matcher_checker #(
    .NUM_PATTERNS(NUM_PATTERNS),
    .MAX_ARG_KEYS(MAX_ARG_KEYS),
    .MAX_LETTERS (MAX_LETTERS)
  ) u_checker (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver: random pop rate that changes now and then, plus a long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop   <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
      pat_left  <= 0;
      pop_pct   <= 100;
    end else if (hold_left != 0) begin
      out_pop   <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_pop   <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      if (pat_left == 0) begin
        case ($urandom_range(0, 3))
          0:       pop_pct <= 100;
          1:       pop_pct <= 80;
          2:       pop_pct <= 50;
          default: pop_pct <= 20;
        endcase
        pat_left <= $urandom_range(20, 120);
      end else begin
        pat_left <= pat_left - 1;
      end
      out_pop <= ($urandom_range(1, 100) <= pop_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("no transfer for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic kbsm_item_t random_item();
    kbsm_item_t it;
    it.func  = CMD_KEY;
    it.key   = 8'($urandom);
    it.idx   = IDX_W'($urandom);
    it.code  = FIELD_W'({$urandom, $urandom});
    it.mask  = FIELD_W'({$urandom, $urandom});
    it.valid = 1'($urandom);
    it.argc  = CNT_W'($urandom);
    it.fixed = 8'($urandom);
    it.cls   = 8'($urandom);
    return it;
  endfunction

  function automatic logic [7:0] letter_key(input logic [4:0] c);
    if (c < 26 && $urandom_range(0, 1)) begin
      return KEY_UC_A + c;
    end
    return KEY_LC_A + c;
  endfunction

  function automatic logic [7:0] nonletter_key();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(8'h00, 8'h40));
      1:       return 8'($urandom_range(8'h5B, 8'h60));
      default: return 8'($urandom_range(8'h81, 8'hFF));
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] letters_mask(input int n);
    return FIELD_W'((64'd1 << (LETTER_BITS * n)) - 64'd1);
  endfunction

  task automatic push_item(input kbsm_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, 99);
      if (no_gap || gap < 30) begin
        gap = 0;
      end else if (gap < 90) begin
        gap = gap % 4 + 1;
      end else begin
        gap = gap % 20 + 1;
      end
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_func            <= it.func;
    in_key             <= it.key;
    in_entry_index     <= it.idx;
    in_entry_code      <= it.code;
    in_entry_mask      <= it.mask;
    in_entry_valid     <= it.valid;
    in_entry_arg_count <= it.argc;
    in_entry_fixed_arg <= it.fixed;
    in_entry_class     <= it.cls;
    in_push            <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    item_count++;
  endtask

  // hold the input until every expected result has come back
  task automatic drain();
    in_push   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [7:0] value);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    inhibit_now  = value;
    setting_count++;
  endtask

  task automatic write_pattern(input int slot, input int n, input logic [FIELD_W-1:0] code,
                               input logic [FIELD_W-1:0] mask, input logic [CNT_W-1:0] argc,
                               input logic [7:0] cls);
    kbsm_item_t it;
    it       = random_item();
    it.func  = CMD_WRITE;
    it.idx   = IDX_W'(slot);
    it.code  = code & mask;
    it.mask  = mask;
    it.valid = 1'b1;
    it.argc  = argc;
    it.cls   = cls;
    push_item(it);
    slot_code[slot]    = code & mask;
    slot_mask[slot]    = mask;
    slot_len[slot]     = n;
    slot_typable[slot] = 1'b1;
  endtask

  task automatic write_random_pattern();
    int                 n;
    int                 g;
    logic [4:0]         c;
    logic [FIELD_W-1:0] code;
    logic [FIELD_W-1:0] mask;
    logic [7:0]         cls;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, MAX_LETTERS) : $urandom_range(1, 4);
    code = '0;
    for (int k = 0; k < n; k++) begin
      c = ($urandom_range(0, 9) == 0) ? 5'd31 : 5'($urandom);
      code = (code << LETTER_BITS) | FIELD_W'(c);
    end
    mask = letters_mask(n);
    // wildcard one letter position now and then
    if (n > 1 && $urandom_range(0, 4) == 0) begin
      g = $urandom_range(0, n - 1);
      mask &= ~(FIELD_W'(5'h1F) << (LETTER_BITS * g));
    end
    case ($urandom_range(0, 3))
      0, 1:    cls = 8'h00;
      2:       cls = 8'($urandom) & ~inhibit_now;
      default: cls = 8'($urandom);
    endcase
    write_pattern($urandom_range(0, IDX_SPAN - 1), n, code, mask,
                  $urandom_range(0, 1) ? CNT_W'(0) : CNT_W'($urandom_range(1, 15)), cls);
  endtask

  task automatic type_letters(input int slot, input int upto);
    kbsm_item_t it;
    int         pos;
    logic [4:0] c;
    for (int k = 0; k < upto; k++) begin
      pos = slot_len[slot] - 1 - k;
      if (slot_mask[slot][LETTER_BITS * pos +: LETTER_BITS] != 0) begin
        c = slot_code[slot][LETTER_BITS * pos +: LETTER_BITS];
      end else begin
        c = 5'($urandom);
      end
      it     = random_item();
      it.key = letter_key(c);
      push_item(it);
    end
  endtask

  initial begin
    kbsm_item_t it;
    int         budget_end;
    int         sel;
    int         slot;
    logic [7:0] directed_keys [18];

    directed_keys = '{8'h41, 8'h42, 8'h00, 8'hFF, 8'h5A, 8'h80,
                      8'h00, 8'hFF, 8'h41, 8'h5A, 8'h80, 8'h7F, 8'h20, 8'h61,
                      8'h63, 8'h64, 8'h43, 8'h01};
    burst_left    = 0;
    no_gap        = 1'b0;
    item_count    = 0;
    setting_count = 0;
    hold_req           <= 1'b0;
    rst_n              <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= 8'h00;
    in_push            <= 1'b0;
    in_func            <= CMD_KEY;
    in_key             <= 8'h00;
    in_entry_index     <= '0;
    in_entry_code      <= '0;
    in_entry_mask      <= '0;
    in_entry_valid     <= 1'b0;
    in_entry_arg_count <= '0;
    in_entry_fixed_arg <= 8'h00;
    in_entry_class     <= 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    cfg_write(8'h7F);

    // "ab" and "b" both match: only the earlier slot fires
    write_pattern(0, 2, 60'd1, letters_mask(2), 4'd0, 8'h00);
    write_pattern(63, 1, 60'd1, letters_mask(1), 4'd0, 8'h00);
    // "z" then key 128, count saturates to eight captured keys
    write_pattern(5, 2, 60'd831, letters_mask(2), 4'd15, 8'h00);
    // "cd" starts a capture while "d" fires at once
    write_pattern(6, 2, 60'd67, letters_mask(2), 4'd2, 8'h80);
    write_pattern(7, 1, 60'd3, letters_mask(1), 4'd0, 8'h00);
    // invalid entry that would match anything
    it       = random_item();
    it.func  = CMD_WRITE;
    it.idx   = IDX_W'(9);
    it.code  = '0;
    it.mask  = '0;
    it.valid = 1'b0;
    push_item(it);
    slot_typable[9] = 1'b0;
    foreach (directed_keys[k]) begin
      it     = random_item();
      it.key = directed_keys[k];
      push_item(it);
    end

    for (int phase = 1; phase <= PHASES; phase++) begin
      drain();
      case ((phase - 1) % 5)
        0:       cfg_write(8'h00);
        1:       cfg_write(8'hFF);
        3:       cfg_write(8'h01 << $urandom_range(0, 7));
        default: cfg_write(8'($urandom));
      endcase
      no_gap = (phase == 3) || (phase == 6);
      // stall the results while the sender keeps pushing
      if (phase == 3) begin
        hold_req <= 1'b1;
      end
      budget_end = item_count + PHASE_ITEMS;
      repeat ($urandom_range(4, 10)) write_random_pattern();
      while (item_count < budget_end) begin
        sel  = $urandom_range(0, 99);
        slot = $urandom_range(0, IDX_SPAN - 1);
        for (int t = 0; t < 32 && !slot_typable[slot]; t++) begin
          slot = $urandom_range(0, IDX_SPAN - 1);
        end
        if (sel < 60 && slot_typable[slot]) begin
          repeat ($urandom_range(0, 2)) begin
            it     = random_item();
            it.key = letter_key(5'($urandom));
            push_item(it);
          end
          type_letters(slot, slot_len[slot]);
        end else if (sel < 72 && slot_typable[slot]) begin
          // broken sequence: partial pattern then a history clear
          type_letters(slot, $urandom_range(0, slot_len[slot] - 1));
          it     = random_item();
          it.key = nonletter_key();
          push_item(it);
        end else if (sel < 90) begin
          it = random_item();
          if ($urandom_range(0, 1)) begin
            it.key = letter_key(5'($urandom));
          end
          push_item(it);
        end else if (sel < 96) begin
          write_random_pattern();
        end else begin
          it      = random_item();
          it.func = CMD_WRITE;
          push_item(it);
          slot_typable[it.idx] = 1'b0;
        end
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d commands under %0d inhibit settings.", item_count,
             setting_count);
    $display("Patterns fired %0d times, %0d of them with captured keys.", fire_count,
             capture_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
